/* hw/rtl/modified_utf8_to_utf16_decoder_macros.svh */
// ----------------------------------------------------------------------------
// Modified UTF-8 decoder assertion macros
// Shared assertion forms for the decoder checker.
// ----------------------------------------------------------------------------
`ifndef MODIFIED_UTF8_TO_UTF16_DECODER_MACROS_SVH
`define MODIFIED_UTF8_TO_UTF16_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MU8DEC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MU8DEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/mu8dec_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modified UTF-8 decoder package
// Shared types and constants for the decoder and its result queue.
// ----------------------------------------------------------------------------
package mu8dec_pkg;

    localparam int BYTE_W   = 8;
    localparam int UNIT_W   = 16;
    localparam int FIFO_DEPTH = 3;
    localparam int PTR_W    = $clog2(FIFO_DEPTH);

    // Number of bytes held from an unfinished sequence.
    typedef enum logic [1:0] {
        HELD_NONE = 2'd0,
        HELD_LEAD = 2'd1,
        HELD_BOTH = 2'd2
    } held_t;

    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              run_last;
        logic              string_end;
    } result_t;

    // Results produced by one byte: count is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } dec_t;

endpackage

/* hw/rtl/mu8dec_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modified UTF-8 decoder: sequence decode
// Holds partial sequence bytes and forms the results of each accepted word.
// ----------------------------------------------------------------------------
module mu8dec_decode
    import mu8dec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              string_last,
    output dec_t              dec
);

    held_t             held_reg, held_next;
    logic [BYTE_W-1:0] lead_reg, lead_next;
    logic [BYTE_W-1:0] second_reg, second_next;

    logic [UNIT_W-1:0] unit_three;
    logic [UNIT_W-1:0] unit_two;
    logic [UNIT_W-1:0] raw_byte;
    logic [UNIT_W-1:0] raw_lead;

    assign unit_three = {lead_reg[3:0], second_reg[5:0], in_byte[5:0]};
    assign unit_two   = {5'd0, lead_reg[4:0], in_byte[5:0]};
    assign raw_byte   = {{(UNIT_W-BYTE_W){1'b0}}, in_byte};
    assign raw_lead   = {{(UNIT_W-BYTE_W){1'b0}}, lead_reg};

    always_comb
    begin
        held_next   = HELD_NONE;
        lead_next   = lead_reg;
        second_next = second_reg;
        dec         = '0;
        // A single result always closes this word's output.
        dec.first.run_last   = 1'b1;
        dec.first.string_end = string_last;
        dec.second.run_last   = 1'b1;
        dec.second.string_end = string_last;
        case (held_reg)
            HELD_BOTH:
            begin
                dec.count           = 2'd1;
                dec.first.code_unit = unit_three;
            end
            HELD_LEAD:
            begin
                if (!lead_reg[5])
                begin
                    dec.count           = 2'd1;
                    dec.first.code_unit = unit_two;
                end
                else if (string_last)
                begin
                    // Truncated three-byte sequence: both bytes go out raw.
                    dec.count            = 2'd2;
                    dec.first.code_unit  = raw_lead;
                    dec.first.run_last   = 1'b0;
                    dec.first.string_end = 1'b0;
                    dec.second.code_unit = raw_byte;
                end
                else
                begin
                    second_next = in_byte;
                    held_next   = HELD_BOTH;
                end
            end
            default:
            begin
                if (!in_byte[7] || string_last)
                begin
                    dec.count           = 2'd1;
                    dec.first.code_unit = raw_byte;
                end
                else
                begin
                    lead_next = in_byte;
                    held_next = HELD_LEAD;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= HELD_NONE;
        end
        else if (accept)
        begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lead_reg   <= lead_next;
            second_reg <= second_next;
        end
    end

endmodule

/* hw/rtl/mu8dec_result_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modified UTF-8 decoder: result queue
// Three-entry ring of result registers taking up to two results per cycle.
// ----------------------------------------------------------------------------
module mu8dec_result_fifo
    import mu8dec_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  dec_t    push,
    input  logic    pop,
    output result_t head,
    output logic    head_valid,
    output logic    room_for_word
);

    result_t          slot_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_plus;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(FIFO_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    assign wr_ptr_plus   = ptr_inc(wr_ptr_reg);
    assign head          = slot_reg[rd_ptr_reg];
    assign head_valid    = (count_reg != 2'd0);
    // A word may bring two results, so at most one may be waiting.
    assign room_for_word = !count_reg[1];

    always_comb
    begin
        case (push.count)
            2'd1:    wr_ptr_next = wr_ptr_plus;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_plus);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + push.count - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < FIFO_DEPTH; i++)
        begin
            if (push.count != 2'd0 && wr_ptr_reg == PTR_W'(i))
            begin
                slot_reg[i] <= push.first;
            end
            else if (push.count == 2'd2 && wr_ptr_plus == PTR_W'(i))
            begin
                slot_reg[i] <= push.second;
            end
        end
    end

endmodule

/* hw/rtl/modified_utf8_to_utf16_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modified UTF-8 to UTF-16 decoder
// Streams encoded bytes in and decoded 16-bit code units out.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one encoded byte per word in s_axis_tdata, with
// s_axis_tlast marking the last byte of a string. The master channel gives
// one UTF-16 code unit per word in m_axis_tdata. m_axis_tuser is set on the
// last result caused by an input byte, and m_axis_tlast on the last result
// of a string. A byte of an unfinished sequence gives no result; when a
// string ends inside a sequence, the held bytes go out raw.
// A result caused by an accepted byte is registered in the result ring and
// shown on the master channel from there. The decode is a single pass of
// logic from the held-byte registers and the input word into a three-entry
// ring of result registers. One byte is taken every cycle while at most one
// result waits; a truncated sequence that gives two results can stall
// the input. When the receiver stalls, results stay in the ring and
// s_axis_tready drops as soon as two are waiting.
// Reset clears the held bytes and empties the ring; the block takes a byte
// in the first cycle after reset.
// ----------------------------------------------------------------------------
module modified_utf8_to_utf16_decoder
    import mu8dec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] in_byte
    input  logic              s_axis_tlast,   // string_last
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [UNIT_W-1:0] m_axis_tdata,   // [15:0] code_unit
    output logic              m_axis_tuser,   // [0] run_last
    output logic              m_axis_tlast    // string_end
);

    logic    accept;
    dec_t    dec;
    dec_t    push;
    result_t head;
    logic    head_valid;
    logic    room_for_word;

    assign accept = s_axis_tvalid && s_axis_tready;

    mu8dec_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_byte     (s_axis_tdata),
        .string_last (s_axis_tlast),
        .dec         (dec)
    );

    // Only an accepted word pushes results.
    always_comb
    begin
        push = dec;
        if (!accept)
        begin
            push.count = 2'd0;
        end
    end

    mu8dec_result_fifo u_result_fifo (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .pop           (m_axis_tvalid && m_axis_tready),
        .head          (head),
        .head_valid    (head_valid),
        .room_for_word (room_for_word)
    );

    assign s_axis_tready = room_for_word;
    assign m_axis_tvalid = head_valid;
    assign m_axis_tdata  = head.code_unit;
    assign m_axis_tuser  = head.run_last;
    assign m_axis_tlast  = head.string_end;

endmodule

/* hw/rtl/mu8dec_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modified UTF-8 decoder checker
// Port-level assertions, bound to the decoder top level.
// ----------------------------------------------------------------------------
`include "modified_utf8_to_utf16_decoder_macros.svh"

module mu8dec_checker
    import mu8dec_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [UNIT_W-1:0] m_axis_tdata,
    input logic              m_axis_tuser,
    input logic              m_axis_tlast
);

    // The end of a string is always the end of its byte's results.
    `MU8DEC_ASSERT_NOW(a_end_is_run_last, clk, rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser, "string end without run end")

    // The first of a pair is always a raw lead byte of a three-byte sequence.
    `MU8DEC_ASSERT_NOW(a_pair_first_raw, clk, rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[15:8] == 8'd0 && m_axis_tdata[7] && m_axis_tdata[5], "bad first result of pair")

    // Both results of a pair are queued together.
    `MU8DEC_ASSERT_NEXT(a_pair_second_ready, clk, rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tuser, m_axis_tvalid, "second result of pair missing")

    // With nothing waiting, the block takes a byte.
    `MU8DEC_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !m_axis_tvalid, s_axis_tready, "not ready while output empty")

    // A stalled result holds.
    `MU8DEC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

endmodule

bind modified_utf8_to_utf16_decoder mu8dec_checker u_mu8dec_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

/* bench/modified_utf8_to_utf16_decoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modified UTF-8 to UTF-16 decoder testbench
// Streams encoded strings through the decoder and checks every decoded
// code unit against a directed table or a behavioral model of the decode,
// with random idle cycles on the input side and random output stalls.
// ----------------------------------------------------------------------------
module modified_utf8_to_utf16_decoder_tb;

    import mu8dec_pkg::*;

    // Number of random-part input words after which no new string starts.
    localparam int RANDOM_WORDS = 700;
    // Number of rows in the directed table.
    localparam int DIR_ROWS     = 25;
    // Cycles to wait after the last expected word.
    localparam int DRAIN_CYCLES = 8;

    localparam result_t NO_UNIT = '0;

    // One row of the directed table. When typed is set, the expected words
    // are taken from the row; otherwise the decode model supplies them.
    typedef struct {
        logic [BYTE_W-1:0] in_data;
        logic              in_last;
        bit                typed;
        int                n_units;
        result_t           unit0;
        result_t           unit1;
    } dir_row_t;

    logic              clk;
    logic              rst_n         = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [BYTE_W-1:0] s_axis_tdata  = '0;   // [7:0] in_byte
    logic              s_axis_tlast  = 1'b0;  // string_last
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [UNIT_W-1:0] m_axis_tdata;          // [15:0] code_unit
    logic              m_axis_tuser;          // [0] run_last
    logic              m_axis_tlast;          // string_end

    // Decode model state: the bytes of an unfinished sequence.
    logic [BYTE_W-1:0] model_lead   = '0;
    logic [BYTE_W-1:0] model_second = '0;
    held_t             model_held   = HELD_NONE;

    // Decoded code units still owed by the block, oldest first.
    result_t pending_units[$];

    int  error_count = 0;
    int  words_sent  = 0;
    int  stall_left  = 0;
    // While quiet is set, neither side starts a new idle stretch.
    logic quiet = 1'b0;

    // The directed table. Rows with typed set carry expectations that can
    // be read straight off the encoding, among them the first word after
    // reset, two- and three-byte extremes and a truncated sequence.
    dir_row_t dir_table [DIR_ROWS] = '{
        // Plain ASCII right after reset, then the largest ASCII byte ending
        // a string.
        '{8'h00, 1'b0, 1'b1, 1, '{16'h0000, 1'b1, 1'b0}, NO_UNIT},
        '{8'h7F, 1'b1, 1'b1, 1, '{16'h007F, 1'b1, 1'b1}, NO_UNIT},
        // A lead byte that ends a string with nothing held goes out raw.
        '{8'hFF, 1'b1, 1'b1, 1, '{16'h00FF, 1'b1, 1'b1}, NO_UNIT},
        '{8'h80, 1'b1, 1'b1, 1, '{16'h0080, 1'b1, 1'b1}, NO_UNIT},
        // Largest two-byte value, mid-string.
        '{8'hDF, 1'b0, 1'b1, 0, NO_UNIT, NO_UNIT},
        '{8'hBF, 1'b0, 1'b1, 1, '{16'h07FF, 1'b1, 1'b0}, NO_UNIT},
        // Smallest two-byte value (the encoded NUL), ending a string.
        '{8'hC0, 1'b0, 1'b1, 0, NO_UNIT, NO_UNIT},
        '{8'h80, 1'b1, 1'b1, 1, '{16'h0000, 1'b1, 1'b1}, NO_UNIT},
        // Largest three-byte value, ending a string.
        '{8'hEF, 1'b0, 1'b1, 0, NO_UNIT, NO_UNIT},
        '{8'hBF, 1'b0, 1'b1, 0, NO_UNIT, NO_UNIT},
        '{8'hBF, 1'b1, 1'b1, 1, '{16'hFFFF, 1'b1, 1'b1}, NO_UNIT},
        // Smallest three-byte value, mid-string.
        '{8'hE0, 1'b0, 1'b1, 0, NO_UNIT, NO_UNIT},
        '{8'h80, 1'b0, 1'b1, 0, NO_UNIT, NO_UNIT},
        '{8'h80, 1'b0, 1'b1, 1, '{16'h0000, 1'b1, 1'b0}, NO_UNIT},
        // Truncated three-byte sequence: both bytes go out raw.
        '{8'hE2, 1'b0, 1'b1, 0, NO_UNIT, NO_UNIT},
        '{8'h82, 1'b1, 1'b1, 2, '{16'h00E2, 1'b0, 1'b0}, '{16'h0082, 1'b1, 1'b1}},
        // Continuation bytes that are not of the form 10xxxxxx.
        '{8'hC3, 1'b0, 1'b0, 0, NO_UNIT, NO_UNIT},
        '{8'h41, 1'b0, 1'b0, 0, NO_UNIT, NO_UNIT},
        '{8'hF5, 1'b0, 1'b0, 0, NO_UNIT, NO_UNIT},
        '{8'h00, 1'b0, 1'b0, 0, NO_UNIT, NO_UNIT},
        '{8'hFF, 1'b0, 1'b0, 0, NO_UNIT, NO_UNIT},
        // Three-byte lead with bit 6 clear, truncated by a lead-like byte.
        '{8'hA5, 1'b0, 1'b0, 0, NO_UNIT, NO_UNIT},
        '{8'hFF, 1'b1, 1'b0, 0, NO_UNIT, NO_UNIT},
        // Two-byte lead with bit 6 clear, completed by an ASCII byte at the
        // end of a string.
        '{8'h9A, 1'b0, 1'b0, 0, NO_UNIT, NO_UNIT},
        '{8'h7F, 1'b1, 1'b0, 0, NO_UNIT, NO_UNIT}
    };

    modified_utf8_to_utf16_decoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard limit on the run.
    initial
    begin
        #1000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Length of an idle stretch: mostly short, now and then long.
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // Decode model: takes one accepted byte, updates the held bytes and
    // returns the zero, one or two code units the byte gives rise to.
    task automatic decode_byte(
        input  logic [BYTE_W-1:0] b,
        input  logic              fin,
        output int                n_units,
        output result_t           unit0,
        output result_t           unit1
    );
        n_units = 0;
        unit0   = NO_UNIT;
        unit1   = NO_UNIT;
        case (model_held)
            HELD_BOTH:
            begin
                // Third byte always completes the sequence, string end or not.
                unit0 = '{code_unit: {model_lead[3:0], model_second[5:0], b[5:0]},
                          run_last: 1'b1, string_end: fin};
                n_units = 1;
                model_held = HELD_NONE;
            end
            HELD_LEAD:
            begin
                if (!model_lead[5])
                begin
                    unit0 = '{code_unit: {5'b00000, model_lead[4:0], b[5:0]},
                              run_last: 1'b1, string_end: fin};
                    n_units = 1;
                    model_held = HELD_NONE;
                end
                else if (fin)
                begin
                    // String ends inside a three-byte sequence: the held
                    // lead and this byte go out raw, one word each.
                    unit0 = '{code_unit: {8'h00, model_lead}, run_last: 1'b0,
                              string_end: 1'b0};
                    unit1 = '{code_unit: {8'h00, b}, run_last: 1'b1,
                              string_end: 1'b1};
                    n_units = 2;
                    model_held = HELD_NONE;
                end
                else
                begin
                    model_second = b;
                    model_held = HELD_BOTH;
                end
            end
            default:
            begin
                // Nothing held. An ASCII byte, or any byte ending a string,
                // goes out as it is; other bytes start a sequence.
                model_held = HELD_NONE;
                if (!b[7] || fin)
                begin
                    unit0 = '{code_unit: {8'h00, b}, run_last: 1'b1, string_end: fin};
                    n_units = 1;
                end
                else
                begin
                    model_lead = b;
                    model_held = HELD_LEAD;
                end
            end
        endcase
        if (model_held == HELD_NONE)
        begin
            model_lead   = '0;
            model_second = '0;
        end
    endtask

    task automatic push_units(input int n_units, input result_t unit0,
                              input result_t unit1);
        if (n_units > 0)
            pending_units.push_back(unit0);
        if (n_units > 1)
            pending_units.push_back(unit1);
    endtask

    // Offers one byte on the slave channel and returns at the edge where
    // it is taken. An idle gap may come first; with no gap, tvalid stays
    // high from the previous word.
    task automatic send_word(input logic [BYTE_W-1:0] b, input logic fin);
        int gap;
        gap = (quiet || $urandom_range(0, 99) < 60) ? 0 : gap_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_axis_tready);
        words_sent++;
    endtask

    // Sends one byte and queues what the decode model expects from it.
    task automatic send_and_predict(input logic [BYTE_W-1:0] b, input logic fin);
        int      n_units;
        result_t unit0;
        result_t unit1;
        send_word(b, fin);
        decode_byte(b, fin, n_units, unit0, unit1);
        push_units(n_units, unit0, unit1);
    endtask

    // A continuation byte: mostly of the form 10xxxxxx, sometimes any byte,
    // since the decoder does not check them.
    function automatic logic [BYTE_W-1:0] cont_byte();
        if ($urandom_range(0, 99) < 85)
            return 8'h80 | BYTE_W'($urandom_range(0, 63));
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // Builds one random string, mostly well formed, and sends it. Lead bytes
    // keep bits 6 and 4..0 random so that malformed leads show up too. Some
    // strings end in the middle of a sequence.
    task automatic send_string();
        logic [BYTE_W-1:0] str_bytes[$];
        int                n_chars;
        int                kind;
        n_chars = $urandom_range(1, 10);
        for (int i = 0; i < n_chars; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
                str_bytes.push_back(BYTE_W'($urandom_range(0, 127)));
            else if (kind < 65)
            begin
                str_bytes.push_back((BYTE_W'($urandom) & 8'hDF) | 8'h80);
                str_bytes.push_back(cont_byte());
            end
            else if (kind < 92)
            begin
                str_bytes.push_back(BYTE_W'($urandom) | 8'hA0);
                str_bytes.push_back(cont_byte());
                str_bytes.push_back(cont_byte());
            end
            else
                str_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
        end
        // Truncated endings: a bare lead, or a three-byte lead plus one byte.
        kind = $urandom_range(0, 99);
        if (kind < 8)
            str_bytes.push_back(BYTE_W'($urandom) | 8'h80);
        else if (kind < 16)
        begin
            str_bytes.push_back(BYTE_W'($urandom) | 8'hA0);
            str_bytes.push_back(cont_byte());
        end
        foreach (str_bytes[i])
            send_and_predict(str_bytes[i], i == str_bytes.size() - 1);
    endtask

    // Both sides switch now and then into a stretch with no idling.
    initial
    begin
        forever
        begin
            repeat ($urandom_range(100, 400)) @(posedge clk);
            quiet <= ($urandom_range(0, 3) == 0);
        end
    end

    // Output side: checks each word taken at an edge against the oldest
    // expectation, then decides whether to stall for the next cycles. The
    // signals read here are the values from before the edge.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_units.size() == 0)
                report_mismatch($sformatf("unexpected word: unit %04h run_last %0b end %0b",
                                          m_axis_tdata, m_axis_tuser, m_axis_tlast));
            else
            begin
                want = pending_units.pop_front();
                if (m_axis_tdata !== want.code_unit)
                    report_mismatch($sformatf("code unit %04h, expected %04h",
                                              m_axis_tdata, want.code_unit));
                if (m_axis_tuser !== want.run_last)
                    report_mismatch($sformatf("run_last %0b, expected %0b (unit %04h)",
                                              m_axis_tuser, want.run_last, want.code_unit));
                if (m_axis_tlast !== want.string_end)
                    report_mismatch($sformatf("string_end %0b, expected %0b (unit %04h)",
                                              m_axis_tlast, want.string_end,
                                              want.code_unit));
            end
        end
        if (stall_left == 0 && !quiet && $urandom_range(0, 99) < 25)
            stall_left = gap_len();
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Main sequence: reset, directed table, random strings, drain.
    initial
    begin
        int      n_units;
        result_t unit0;
        result_t unit1;
        bit      paused;

        paused = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Every row runs through the decode model so that the
        // held bytes stay in step; typed rows queue their own expectations.
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            send_word(dir_table[r].in_data, dir_table[r].in_last);
            decode_byte(dir_table[r].in_data, dir_table[r].in_last,
                        n_units, unit0, unit1);
            if (dir_table[r].typed)
                push_units(dir_table[r].n_units, dir_table[r].unit0, dir_table[r].unit1);
            else
                push_units(n_units, unit0, unit1);
        end

        // Hold off the sender until every decoded word has come out.
        s_axis_tvalid <= 1'b0;
        while (pending_units.size() != 0)
            @(posedge clk);

        // Random part; halfway through, the sender pauses once more until
        // the output side has drained.
        while (words_sent < DIR_ROWS + RANDOM_WORDS)
        begin
            send_string();
            if (!paused && words_sent > DIR_ROWS + RANDOM_WORDS / 2)
            begin
                paused = 1'b1;
                s_axis_tvalid <= 1'b0;
                while (pending_units.size() != 0)
                    @(posedge clk);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_units.size() != 0)
            @(posedge clk);
        // Then wait on, to catch any word the block sends beyond those expected.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_units.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/mu8dec_pkg.sv
hw/rtl/mu8dec_decode.sv
hw/rtl/mu8dec_result_fifo.sv
hw/rtl/modified_utf8_to_utf16_decoder.sv
hw/rtl/mu8dec_checker.sv
bench/modified_utf8_to_utf16_decoder_tb.sv
